FILE: rtl/core/scpdo_pkg.sv
package scpdo_pkg;

  // Packed widths of the stream payloads
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 32;

  // Field widths
  localparam int VOICE_W = 4;
  localparam int INC_W   = 25;
  localparam int EXT_W   = 24;
  localparam int Q16_W   = 17;
  localparam int WARP_W  = 25;

  // 1.0 in Q1.16
  localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;

  // Item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_SETUP,
    ST_DECIDE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/scpdo_ram.sv
module scpdo_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/skew_clip_phase_distortion_osc_core.sv
// Skew/clip phase-distortion oscillator, one stored phase per voice.
//
// Input stream (s_*): one transfer carries voice, signed phase increment,
// external phase, skew and clip. The selected voice's phase is advanced by
// the increment (wrapping modulo 1) or, in external mode, replaced by the
// external phase, then warped piecewise-linearly by skew and clip.
// Output stream (m_*): one transfer per input item with the voice and the
// warped phase in Q1.PHASE_BITS.
// Configuration: cfg_we writes cfg_wdata into the external-mode bit; write
// it only while no item is in flight.
// Sequence: an accepted item passes the READ, MUL1, MUL2, SETUP and DECIDE
// states, then, when the warp divides, the bit-serial restoring divider,
// one quotient bit per cycle; a warp on a flat segment skips the divide.
// A new input is taken only once the previous result has entered the output
// register.
// The output register parts the two sides: a new item is taken while a
// result waits. If the receiver stalls, the next finished result holds in
// the sequencer and s_tready stays low until the output register frees.
// Reset clears the sequencer, the output valid, the mode bit and the voice
// valid bits, so every stored phase reads as zero until first written.
module skew_clip_phase_distortion_osc_core #(
  parameter int VOICES     = 16,
  parameter int PHASE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  // cfg_wdata: external_phase_mode
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata, lowest bit up: voice[3:0], phase_increment[28:4],
  // external_phase[52:29], skew[69:53], clip[86:70], zero pad[87]
  input  logic [scpdo_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata, lowest bit up: voice_out[3:0], warped_phase[28:4], zero pad[31:29]
  output logic [scpdo_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import scpdo_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int QW = PHASE_BITS - 1;
  localparam int CW = $clog2(PHASE_BITS);
  localparam int IW = (PHASE_BITS > INC_W) ? PHASE_BITS : INC_W;

  // Voice index reduced modulo VOICES, one entry per 4-bit code
  function automatic logic [16*VW-1:0] build_voice_map();
    logic [16*VW-1:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      m[i*VW +: VW] = VW'(i % VOICES);
    end
    return m;
  endfunction

  localparam logic [16*VW-1:0] VOICE_MAP = build_voice_map();

  state_t state, state_next;

  logic                    mode;
  logic [VOICES-1:0]       valid;
  logic [VW-1:0]           voice_reg;
  logic signed [INC_W-1:0] inc_reg;
  logic [EXT_W-1:0]        ext_reg;
  logic [Q16_W-1:0]        skew_reg;
  logic [Q16_W-1:0]        oclip_reg;
  logic [PHASE_BITS-1:0]   phase;
  logic [32:0]             ct1;
  logic [32:0]             span2;
  logic [32:0]             ct2;
  logic                    lo;
  logic [32:0]             rem;
  logic [32:0]             den;
  logic [QW-1:0]           quo;
  logic [1:0]              top;
  logic [CW-1:0]           cnt;
  logic [VOICE_W-1:0]      out_voice;
  logic [WARP_W-1:0]       out_warp;

  logic                    accept;
  logic                    ram_re;
  logic                    ram_we;
  logic                    load_out;
  logic [VW-1:0]           rd_addr;
  logic [PHASE_BITS-1:0]   rd_data;
  logic [PHASE_BITS-1:0]   stored;
  logic signed [IW-1:0]    inc_w;
  logic [PHASE_BITS-1:0]   phase_next;

  logic [VOICE_W-1:0]      in_voice;
  logic [INC_W-1:0]        in_inc;
  logic [EXT_W-1:0]        in_ext;
  logic [Q16_W-1:0]        in_skew;
  logic [Q16_W-1:0]        in_clip;
  logic [Q16_W-1:0]        sat_skew;
  logic [Q16_W-1:0]        sat_clip;

  logic [Q16_W-1:0]        mul_a;
  logic [33:0]             prod;
  logic [31:0]             ph;
  logic [32:0]             sk;
  logic [32:0]             limit;
  logic [33:0]             trial;
  logic [33:0]             diff;
  logic                    ge;

  // Unpack the input transfer
  assign in_voice = s_tdata[3:0];
  assign in_inc   = s_tdata[28:4];
  assign in_ext   = s_tdata[52:29];
  assign in_skew  = s_tdata[69:53];
  assign in_clip  = s_tdata[86:70];
  assign sat_skew = (in_skew > Q16_ONE) ? Q16_ONE : in_skew;
  assign sat_clip = (in_clip > Q16_ONE) ? Q16_ONE : in_clip;
  assign rd_addr  = VOICE_MAP[in_voice*VW +: VW];

  assign accept = s_tvalid && s_tready;

  // Phase store
  scpdo_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (VOICES)
  ) u_phase_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (voice_reg),
    .wdata (phase_next),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // New phase: external value or wrapped accumulation
  assign stored     = valid[voice_reg] ? rd_data : '0;
  assign inc_w      = IW'(inc_reg);
  assign phase_next = mode ? PHASE_BITS'(ext_reg) : PHASE_BITS'(stored + PHASE_BITS'(inc_w));

  // Shared multiplier for ct1 and the upper span
  assign mul_a = (state == ST_MUL1) ? skew_reg : (Q16_ONE - skew_reg);
  assign prod  = 34'(mul_a) * 34'(oclip_reg);

  // Phase in Q0.32 and skew in Q1.32
  assign ph    = 32'(phase) << (32 - PHASE_BITS);
  assign sk    = {skew_reg, 16'd0};
  assign limit = lo ? ct1 : ct2;

  // One restoring divide step
  assign trial = {rem, 1'b0};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_READ;
      ST_READ:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = ({1'b0, ph} < limit) ? ST_DIV : ST_DONE;
      ST_DIV:    if (cnt == CW'(QW - 1)) state_next = ST_DONE;
      ST_DONE:   if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_re   = s_tvalid;
      end
      ST_READ: ram_we   = 1'b1;
      ST_DONE: load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= 1'b0;
      valid    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (ram_we) begin
        valid[voice_reg] <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      voice_reg <= rd_addr;
      inc_reg   <= in_inc;
      ext_reg   <= in_ext;
      skew_reg  <= sat_skew;
      oclip_reg <= Q16_ONE - sat_clip;
    end
    case (state)
      ST_READ: phase <= phase_next;
      ST_MUL1: ct1   <= 33'(prod);
      ST_MUL2: span2 <= 33'(prod);
      ST_SETUP: begin
        lo  <= ({1'b0, ph} < sk);
        ct2 <= 33'(34'(sk) + 34'(span2));
      end
      ST_DECIDE: begin
        // Pick the segment; flat segments skip the divide
        quo <= '0;
        cnt <= '0;
        if (lo) begin
          rem <= {1'b0, ph};
          den <= ct1;
          top <= ({1'b0, ph} < ct1) ? 2'b00 : 2'b01;
        end else begin
          rem <= {1'b0, ph} - sk;
          den <= span2;
          top <= ({1'b0, ph} < ct2) ? 2'b01 : 2'b10;
        end
      end
      ST_DIV: begin
        // Shift in one quotient bit
        rem <= ge ? 33'(diff) : 33'(trial);
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
    if (load_out) begin
      out_voice <= VOICE_W'(voice_reg);
      out_warp  <= WARP_W'({top, quo});
    end
  end

  assign m_tdata = {3'b000, out_warp, out_voice};

  // Checks
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_READ)
    else $error("accepted item did not start the phase read");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < den)
    else $error("divider remainder reached the divisor");

  a_voice_marked: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> valid[voice_reg])
    else $error("written voice not marked valid");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid && state == ST_IDLE)
    else $error("result load did not raise m_tvalid");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import scpdo_pkg::*;

  localparam int NUM_VOICES = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [63:0] HALF_TURN = 64'd1 << 23;
  localparam logic [63:0] FULL_TURN = 64'd1 << 24;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [INC_W-1:0]   inc;
    logic [EXT_W-1:0]   ext;
    logic [Q16_W-1:0]   skew;
    logic [Q16_W-1:0]   clip;
  } osc_item_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [WARP_W-1:0]  warp;
  } warp_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // s_tdata, lowest bit up: voice, phase_increment, external_phase, skew, clip, zero pad
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // m_tdata, lowest bit up: voice_out, warped_phase, zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Predictor state
  logic [EXT_W-1:0] voice_phase [NUM_VOICES];
  logic             ext_mode = 1'b0;
  warp_result_t     pending_warps [$];

  int  items_sent = 0;
  int  results_seen = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_stalls = 1'b1;
  int  stall_left = 0;
  int unsigned rx_pick;

  logic [VOICE_W-1:0] in_voice;
  logic [EXT_W-1:0]   new_phase;
  warp_result_t       want;

  skew_clip_phase_distortion_osc_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_VOICES; i++) voice_phase[i] = '0;
  end

  // Saturate a Q1.16 fraction at 1.0
  function automatic logic [63:0] clamp_q16(logic [Q16_W-1:0] v);
    return (v > Q16_ONE) ? 64'(Q16_ONE) : 64'(v);
  endfunction

  // Piecewise-linear skew/clip warp of a Q0.24 phase, result in Q1.24
  function automatic logic [WARP_W-1:0] warp_phase(logic [EXT_W-1:0] p,
                                                   logic [Q16_W-1:0] skew_in,
                                                   logic [Q16_W-1:0] clip_in);
    logic [63:0] ph, sw, cl, sk, ct1, span2, ct2;
    ph = {32'd0, p, 8'd0};
    sw = clamp_q16(skew_in);
    cl = clamp_q16(clip_in);
    sk = sw << 16;
    ct1 = sw * (64'd65536 - cl);
    span2 = (64'd65536 - sw) * (64'd65536 - cl);
    ct2 = sk + span2;
    if (ph < sk) begin
      if (ph < ct1) return WARP_W'((ph * HALF_TURN) / ct1);
      return WARP_W'(HALF_TURN);
    end
    if (ph < ct2) return WARP_W'(HALF_TURN + ((ph - sk) * HALF_TURN) / span2);
    return WARP_W'(FULL_TURN);
  endfunction

  // Track register writes, predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) ext_mode = cfg_wdata;

      if (s_tvalid && s_tready) begin
        in_voice = s_tdata[3:0];
        if (ext_mode) new_phase = s_tdata[52:29];
        else new_phase = voice_phase[in_voice] + s_tdata[27:4];
        voice_phase[in_voice] = new_phase;
        want.voice = in_voice;
        want.warp = warp_phase(new_phase, s_tdata[69:53], s_tdata[86:70]);
        pending_warps.push_back(want);
      end

      if (m_tvalid && m_tready) begin
        if (pending_warps.size() == 0) begin
          $error("unexpected result: voice_out %0d warped_phase %0d",
                 m_tdata[3:0], m_tdata[28:4]);
          errors++;
        end else begin
          want = pending_warps.pop_front();
          if (m_tdata[3:0] !== want.voice) begin
            $error("voice_out: expected %0d, got %0d", want.voice, m_tdata[3:0]);
            errors++;
          end
          if (m_tdata[28:4] !== want.warp) begin
            $error("warped_phase: expected %0d, got %0d", want.warp, m_tdata[28:4]);
            errors++;
          end
          results_seen++;
        end
      end
    end
  end

  // Receiver: random stalls, mostly short, a few long
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_stalls) begin
      m_tready <= 1'b1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall_left <= (rx_pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[skew_clip_phase_distortion_osc_core] ERROR");
      $finish;
    end
  end

  function automatic osc_item_t make_item(int v, logic [INC_W-1:0] inc,
                                          logic [EXT_W-1:0] ext,
                                          logic [Q16_W-1:0] skew,
                                          logic [Q16_W-1:0] clip);
    osc_item_t it;
    it.voice = VOICE_W'(v);
    it.inc = inc;
    it.ext = ext;
    it.skew = skew;
    it.clip = clip;
    return it;
  endfunction

  function automatic logic [Q16_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return Q16_ONE;
      2: return Q16_W'($urandom_range(65537, 131071));
      3: return Q16_W'($urandom_range(0, 64));
      4: return Q16_W'($urandom_range(65472, 65536));
      default: return Q16_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic osc_item_t rand_item();
    osc_item_t it;
    it.voice = VOICE_W'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: it.inc = INC_W'($urandom);
      1: it.inc = INC_W'($urandom_range(0, 2000)) - INC_W'(1000);
      default: it.inc = INC_W'($urandom_range(0, 16777216)) - INC_W'(8388608);
    endcase
    it.ext = EXT_W'($urandom);
    it.skew = rand_q16();
    it.clip = rand_q16();
    return it;
  endfunction

  function automatic int tx_gap();
    int unsigned r;
    if (!tx_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until the transfer; leave tvalid high for a following item
  task automatic send_item(input osc_item_t it);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, it.clip, it.skew, it.ext, it.inc, it.voice};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Hold the sender off until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    repeat (n) send_item(rand_item());
  endtask

  // Accumulation corners: wrap both ways, increment extremes, flat and degenerate warps
  task automatic test_internal_corners();
    set_mode(1'b0);
    send_item(make_item(0, 25'd0, 24'd0, 17'd32768, 17'd0));
    send_item(make_item(0, 25'h0400000, 24'hFFFFFF, 17'd32768, 17'd0));
    send_item(make_item(0, 25'h0400000, 24'h000000, 17'd32768, 17'd32768));
    send_item(make_item(0, 25'h07FFFFF, 24'h555555, 17'd16384, Q16_ONE));
    send_item(make_item(1, 25'd8388608, 24'hAAAAAA, Q16_ONE, 17'd0));
    send_item(make_item(1, -25'sd8388608, 24'h0, 17'd0, 17'd0));
    send_item(make_item(2, 25'h1000000, 24'h0, 17'd131071, 17'd131071));
    send_item(make_item(2, 25'h0FFFFFF, 24'h0, 17'd0, Q16_ONE));
    send_item(make_item(15, 25'd1, 24'h0, 17'd65537, 17'd70000));
    send_item(make_item(15, 25'h1FFFFFF, 24'h0, 17'd1, 17'd65535));
    send_item(make_item(15, 25'h1FFFFFF, 24'h0, 17'd65535, 17'd1));
    send_item(make_item(7, 25'h0123456, 24'hFFFFFF, 17'd40000, 17'd20000));
    send_item(make_item(8, 25'h0800000, 24'h0, Q16_ONE, Q16_ONE));
  endtask

  // External phase corners, including phase exactly on the skew point
  task automatic test_external_corners();
    set_mode(1'b1);
    send_item(make_item(3, 25'h1FFFFFF, 24'h000000, 17'd32768, 17'd0));
    send_item(make_item(3, 25'h0, 24'hFFFFFF, 17'd32768, 17'd0));
    send_item(make_item(3, 25'h1000000, 24'h800000, 17'd32768, 17'd16384));
    send_item(make_item(4, 25'h0FFFFFF, 24'h7FFFFF, 17'd32768, 17'd65535));
    send_item(make_item(4, 25'h0, 24'h000001, 17'd1, 17'd131071));
    send_item(make_item(5, 25'h0, 24'hFFFFFF, Q16_ONE, 17'd65537));
    // Back to accumulation: the voices written above must carry on from the external phase
    set_mode(1'b0);
    send_item(make_item(3, 25'h0000100, 24'h0, 17'd30000, 17'd10000));
    send_item(make_item(4, 25'h1FFFF00, 24'h0, 17'd50000, 17'd5000));
  endtask

  task automatic test_random_internal();
    set_mode(1'b0);
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    run_random(600);
  endtask

  task automatic test_random_external();
    set_mode(1'b1);
    run_random(450);
  endtask

  // No idling on either side, then random receiver stalls with a gapless sender
  task automatic test_back_to_back();
    set_mode(1'b0);
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    run_random(150);
    rx_stalls = 1'b1;
    run_random(150);
    tx_gaps = 1'b1;
  endtask

  // Sender pauses mid-stream until all results are in, then carries on in both modes
  task automatic test_pause_and_switch();
    run_random(80);
    wait_drained();
    run_random(60);
    set_mode(1'b1);
    run_random(70);
    set_mode(1'b0);
    run_random(70);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_internal_corners();
    test_external_corners();
    test_random_internal();
    test_random_external();
    test_back_to_back();
    test_pause_and_switch();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[skew_clip_phase_distortion_osc_core] OK");
    end else begin
      $display("[skew_clip_phase_distortion_osc_core] ERROR");
    end
    $finish;
  end

endmodule
